// ===== sv/tksl_pkg.sv =====
// Shared constants, payload types and memory interface of the top-k score list.
package tksl_pkg;

  localparam int LIST_DEPTH = 16;
  localparam int TAG_BITS   = 16;

  localparam int IDX_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  localparam int SCORE_W   = 32;
  localparam int IN_TAG_W  = 16;
  localparam int RANK_W    = 4;
  localparam int COUNT_W   = 5;
  localparam int INDEX_W   = 4;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_READ   = 1'b1;

  typedef struct packed {
    logic                       action;
    logic signed [SCORE_W-1:0]  new_score;
    logic [IN_TAG_W-1:0]        new_tag;
    logic [INDEX_W-1:0]         read_index;
  } cmd_t;

  typedef struct packed {
    logic                       accepted;
    logic [RANK_W-1:0]          placed_rank;
    logic [COUNT_W-1:0]         entry_count;
    logic                       read_valid;
    logic signed [SCORE_W-1:0]  read_score;
    logic [IN_TAG_W-1:0]        read_tag;
  } res_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0]  score;
    logic [TAG_BITS-1:0]        tag;
  } entry_t;

  typedef struct packed {
    logic [IDX_W-1:0]           raddr;
    logic                       we;
    logic [IDX_W-1:0]           waddr;
    entry_t                     wdata;
  } mem_req_t;

endpackage

// ===== sv/tksl_mem.sv =====
// Ranked entry store: one write port, one registered read port.
module tksl_mem import tksl_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output entry_t   rdata_o
);

  entry_t mem_q [LIST_DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/tksl_ctrl.sv =====
// Sequencer for scan, shift, place and read over the ranked entry store.
module tksl_ctrl import tksl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  cmd_t     cmd_i,
  output logic     busy,
  output logic     strobe_o,
  output res_t     res_o,
  output mem_req_t mem_req_o,
  input  entry_t   mem_rdata_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_PLACE,
    ST_READ
  } state_e;

  state_e                    state_q, state_d;
  logic signed [SCORE_W-1:0] score_q, score_d;
  logic [TAG_BITS-1:0]       tag_q, tag_d;
  logic [CNT_W-1:0]          pos_q, pos_d;
  logic                      eq_q, eq_d;
  logic [IDX_W-1:0]          eq_pos_q, eq_pos_d;
  logic [CNT_W-1:0]          wr_q, wr_d;
  logic [CNT_W-1:0]          count_q, count_d;
  logic                      rvalid_q, rvalid_d;
  logic                      strobe_q, strobe_d;
  res_t                      res_q, res_d;
  logic [CNT_W-1:0]          last;
  logic [CNT_W-1:0]          pos_inc;
  logic [CNT_W-1:0]          wr_dec;
  entry_t                    new_entry;

  assign last      = (count_q < CNT_W'(LIST_DEPTH)) ? count_q : CNT_W'(LIST_DEPTH - 1);
  assign pos_inc   = pos_q + CNT_W'(1);
  assign wr_dec    = wr_q - CNT_W'(1);
  assign new_entry = '{score: score_q, tag: tag_q};

  always_comb begin
    state_d   = state_q;
    score_d   = score_q;
    tag_d     = tag_q;
    pos_d     = pos_q;
    eq_d      = eq_q;
    eq_pos_d  = eq_pos_q;
    wr_d      = wr_q;
    count_d   = count_q;
    rvalid_d  = rvalid_q;
    strobe_d  = 1'b0;
    res_d     = res_q;
    mem_req_o = '{raddr: '0, we: 1'b0, waddr: '0, wdata: new_entry};

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (cmd_i.action == ACT_INSERT) begin
            score_d = cmd_i.new_score;
            tag_d   = TAG_BITS'(cmd_i.new_tag);
            pos_d   = '0;
            eq_d    = 1'b0;
            state_d = (count_q == '0) ? ST_DECIDE : ST_SCAN;
          end else begin
            rvalid_d        = (($bits(count_q) + INDEX_W)'(cmd_i.read_index)
                               < ($bits(count_q) + INDEX_W)'(count_q));
            mem_req_o.raddr = IDX_W'(cmd_i.read_index);
            state_d         = ST_READ;
          end
        end
      end
      ST_SCAN: begin
        mem_req_o.raddr = IDX_W'(pos_inc);
        if (mem_rdata_i.score < score_q) begin
          state_d = ST_DECIDE;
        end else begin
          if (mem_rdata_i.score == score_q) begin
            eq_d     = 1'b1;
            eq_pos_d = IDX_W'(pos_q);
          end
          pos_d = pos_inc;
          if (pos_inc == count_q) begin
            state_d = ST_DECIDE;
          end
        end
      end
      ST_DECIDE: begin
        if (eq_q) begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = eq_pos_q;
          res_d           = '0;
          res_d.accepted  = 1'b1;
          res_d.placed_rank = RANK_W'(eq_pos_q);
          strobe_d        = 1'b1;
          state_d         = ST_IDLE;
        end else if (pos_q == CNT_W'(LIST_DEPTH)) begin
          res_d    = '0;
          strobe_d = 1'b1;
          state_d  = ST_IDLE;
        end else if (last == pos_q) begin
          state_d = ST_PLACE;
        end else begin
          mem_req_o.raddr = IDX_W'(last - CNT_W'(1));
          wr_d            = last;
          state_d         = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = IDX_W'(wr_q);
        mem_req_o.wdata = mem_rdata_i;
        mem_req_o.raddr = IDX_W'(wr_q - CNT_W'(2));
        if (wr_dec == pos_q) begin
          state_d = ST_PLACE;
        end else begin
          wr_d = wr_dec;
        end
      end
      ST_PLACE: begin
        mem_req_o.we      = 1'b1;
        mem_req_o.waddr   = IDX_W'(pos_q);
        if (count_q < CNT_W'(LIST_DEPTH)) begin
          count_d = count_q + CNT_W'(1);
        end
        res_d             = '0;
        res_d.accepted    = 1'b1;
        res_d.placed_rank = RANK_W'(pos_q);
        strobe_d          = 1'b1;
        state_d           = ST_IDLE;
      end
      ST_READ: begin
        res_d            = '0;
        res_d.read_valid = rvalid_q;
        if (rvalid_q) begin
          res_d.read_score = mem_rdata_i.score;
          res_d.read_tag   = IN_TAG_W'(mem_rdata_i.tag);
        end
        strobe_d = 1'b1;
        state_d  = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    res_d.entry_count = COUNT_W'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      score_q  <= '0;
      tag_q    <= '0;
      pos_q    <= '0;
      eq_q     <= 1'b0;
      eq_pos_q <= '0;
      wr_q     <= '0;
      count_q  <= '0;
      rvalid_q <= 1'b0;
      strobe_q <= 1'b0;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      score_q  <= score_d;
      tag_q    <= tag_d;
      pos_q    <= pos_d;
      eq_q     <= eq_d;
      eq_pos_q <= eq_pos_d;
      wr_q     <= wr_d;
      count_q  <= count_d;
      rvalid_q <= rvalid_d;
      strobe_q <= strobe_d;
      res_q    <= res_d;
    end
  end

  assign busy     = (state_q != ST_IDLE);
  assign strobe_o = strobe_q;
  assign res_o    = res_q;

endmodule

// ===== sv/top_k_sorted_score_list.sv =====
// Top level of the top-k sorted score list.
//
//  channel   | handshake            | word
//  ----------+----------------------+--------
//  command   | start high, busy low | cmd_i
//  result    | strobe_o, one cycle  | res_o
//
// An insert scans from rank 0, one entry per cycle from the shared read port, until it
// meets a lower score or the list's end, then shifts the entries below that rank down
// one per cycle and writes the new word; it overwrites an entry of equal score in place,
// and a full list holding no lower score rejects it. A read returns the registered word.
// One command is in flight; busy stays high until the result is issued. Reset empties
// the list; stored entries are not cleared. Results cannot be stalled.
module top_k_sorted_score_list import tksl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  cmd_t cmd_i,
  output logic busy,
  output logic strobe_o,
  output res_t res_o
);

  mem_req_t mem_req;
  entry_t   mem_rdata;

  tksl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .cmd_i       (cmd_i),
    .busy        (busy),
    .strobe_o    (strobe_o),
    .res_o       (res_o),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  tksl_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule

// ===== sv/tksl_chk.sv =====
// Port-level checker for the top-k sorted score list, bound to the top level.
module tksl_chk import tksl_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input cmd_t cmd_i,
  input logic busy,
  input logic strobe_o,
  input res_t res_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !strobe_o))
    else $error("command accepted without going busy");

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> !busy)
    else $error("result issued while busy");

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |=> !strobe_o)
    else $error("result strobe held for two cycles");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> (res_o.entry_count <= COUNT_W'(LIST_DEPTH)
                  && !(res_o.accepted && res_o.read_valid)))
    else $error("bad entry count or mixed insert and read result");

  a_read_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !res_o.read_valid) |-> (res_o.read_score == '0 && res_o.read_tag == '0))
    else $error("read word not zero when invalid");

endmodule

bind top_k_sorted_score_list tksl_chk u_tksl_chk (.*);

// ===== tb/tb_ranked_list_pkg.sv =====
// Tracker class that mirrors the ranked score list and checks result words.
`timescale 1ns / 100ps
package tb_ranked_list_pkg;
  import tksl_pkg::*;

  class ranked_list_tracker;
    logic signed [SCORE_W-1:0] scores [LIST_DEPTH];
    logic [TAG_BITS-1:0]       tags [LIST_DEPTH];
    int                        count;
    res_t                      expected_words [$];
    int unsigned               errors;

    function new();
      count  = 0;
      errors = 0;
      foreach (scores[i]) begin
        scores[i] = '0;
        tags[i]   = '0;
      end
    endfunction

    function void note_command(cmd_t c);
      res_t                      r;
      logic signed [SCORE_W-1:0] s;
      int                        pos;
      int                        hit;
      int                        last;
      r   = '0;
      s   = c.new_score;
      pos = 0;
      hit = -1;
      if (c.action == ACT_INSERT) begin
        while (pos < count && scores[pos] >= s) begin
          if (scores[pos] == s) hit = pos;
          pos++;
        end
        if (hit >= 0) begin
          scores[hit]   = s;
          tags[hit]     = TAG_BITS'(c.new_tag);
          r.accepted    = 1'b1;
          r.placed_rank = RANK_W'(hit);
        end else if (pos < LIST_DEPTH) begin
          last = (count < LIST_DEPTH) ? count : LIST_DEPTH - 1;
          for (int i = last; i > pos; i--) begin
            scores[i] = scores[i-1];
            tags[i]   = tags[i-1];
          end
          scores[pos] = s;
          tags[pos]   = TAG_BITS'(c.new_tag);
          if (count < LIST_DEPTH) count++;
          r.accepted    = 1'b1;
          r.placed_rank = RANK_W'(pos);
        end
      end else if (int'(c.read_index) < count) begin
        r.read_valid = 1'b1;
        r.read_score = scores[c.read_index];
        r.read_tag   = IN_TAG_W'(tags[c.read_index]);
      end
      r.entry_count = COUNT_W'(count);
      expected_words.push_back(r);
    endfunction

    function void compare(string field, logic [SCORE_W-1:0] want, logic [SCORE_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
        errors++;
      end
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (expected_words.size() == 0) begin
        $display("%0t: result word with no command pending: %h", $time, got);
        errors++;
        return;
      end
      want = expected_words.pop_front();
      compare("accepted", want.accepted, got.accepted);
      compare("placed_rank", want.placed_rank, got.placed_rank);
      compare("entry_count", want.entry_count, got.entry_count);
      compare("read_valid", want.read_valid, got.read_valid);
      compare("read_score", want.read_score, got.read_score);
      compare("read_tag", want.read_tag, got.read_tag);
    endfunction
  endclass

endpackage

// ===== tb/tb_top_k_sorted_score_list.sv =====
// Testbench top for the top-k sorted score list: directed and random commands.
`timescale 1ns / 100ps
module tb_top_k_sorted_score_list;
  import tksl_pkg::*;
  import tb_ranked_list_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_WORDS = 2000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  cmd_t cmd_i  = '0;
  logic busy;
  logic strobe_o;
  res_t res_o;

  ranked_list_tracker board;
  int                 idle_pct;
  int unsigned        quiet_cycles = 0;

  top_k_sorted_score_list DUT (
    .clk_i,
    .rst_ni,
    .start,
    .cmd_i,
    .busy,
    .strobe_o,
    .res_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) board.note_command(cmd_i);
      if (strobe_o) board.check_result(res_o);
      if ((start && !busy) || strobe_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic issue_word(cmd_t c);
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic insert_word(logic [SCORE_W-1:0] score, logic [IN_TAG_W-1:0] tag);
    cmd_t c;
    c.action     = ACT_INSERT;
    c.new_score  = score;
    c.new_tag    = tag;
    c.read_index = INDEX_W'($urandom);
    issue_word(c);
  endtask

  task automatic read_word(int unsigned index);
    cmd_t c;
    c.action     = ACT_READ;
    c.new_score  = $urandom;
    c.new_tag    = IN_TAG_W'($urandom);
    c.read_index = INDEX_W'(index);
    issue_word(c);
  endtask

  function automatic logic [SCORE_W-1:0] pick_score();
    int unsigned roll;
    longint      base;
    longint      nudged;
    roll = $urandom_range(99);
    if (roll < 10) begin
      case ($urandom_range(3))
        0: return 32'h7fff_ffff;
        1: return 32'h8000_0000;
        2: return 32'hffff_ffff;
        default: return 32'h0;
      endcase
    end
    if (roll < 25 || board.count == 0) return $urandom;
    base   = longint'(board.scores[$urandom_range(board.count - 1)]);
    nudged = base + longint'(int'($urandom_range(6)) - 3);
    if (nudged > 64'sd2147483647 || nudged < -64'sd2147483648) return SCORE_W'(base);
    return SCORE_W'(nudged);
  endfunction

  initial begin
    board    = new();
    idle_pct = 14;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    read_word(0);
    read_word(15);
    insert_word(32'h7fff_ffff, 16'hffff);
    insert_word(32'h0, 16'h0);
    insert_word(32'h7fff_ffff, 16'h5a5a);
    insert_word(32'hffff_ffff, 16'h0001);
    read_word(0);
    read_word(3);
    for (int k = 1; k <= 13; k++)
      insert_word(SCORE_W'(((k * 7) % 13) * 1000 - 5999), IN_TAG_W'(k * 4099));
    insert_word(32'h8000_0000, 16'h1234);
    insert_word(SCORE_W'(2000000), 16'h8421);
    insert_word(SCORE_W'(-4999), 16'hbeef);
    read_word(15);

    for (int p = 0; p < 3; p++) begin
      idle_pct = (p == 0) ? 14 : (p == 1) ? 60 : 0;
      for (int n = 0; n < RANDOM_WORDS / 3; n++) begin
        if ($urandom_range(99) < 35) read_word($urandom_range(15));
        else insert_word(pick_score(), IN_TAG_W'($urandom));
      end
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (board.expected_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== top_k_sorted_score_list.f =====
sv/tksl_pkg.sv
sv/tksl_mem.sv
sv/tksl_ctrl.sv
sv/top_k_sorted_score_list.sv
sv/tksl_chk.sv
tb/tb_ranked_list_pkg.sv
tb/tb_top_k_sorted_score_list.sv
